// File: rtl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define CHK_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define CHK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/aes_cbc_pkg.sv
// constants, tables and round functions for the aes-128 cbc unit
package aes_cbc_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int KEY_DEPTH   = ROUND_COUNT + 1;
    localparam int KEY_AW      = $clog2(KEY_DEPTH);
    localparam int BLK_W       = 128;

    localparam logic [2:0] REG_KEY_HIGH     = 3'd0;
    localparam logic [2:0] REG_KEY_LOW      = 3'd1;
    localparam logic [2:0] REG_IV_HIGH      = 3'd2;
    localparam logic [2:0] REG_IV_LOW       = 3'd3;
    localparam logic [2:0] REG_DECRYPT_MODE = 3'd4;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // inverse affine map of the s-box
    function automatic logic [7:0] aff_inv(input logic [7:0] v);
        return {v[6:0], v[7]} ^ {v[4:0], v[7:5]} ^ {v[1:0], v[7:2]} ^ 8'h05;
    endfunction

    // inverse s-box from the forward table: the gf inverse sits between two affine maps
    function automatic logic [7:0] rev_sub_byte(input logic [7:0] y);
        return aff_inv(SBOX[aff_inv(y)]);
    endfunction

    // byte i of a block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input logic [BLK_W-1:0] b, input int i);
        return b[BLK_W-1-8*i -: 8];
    endfunction

    function automatic logic [BLK_W-1:0] sub_shift_fwd(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        t = '0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[BLK_W-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) & 3))];
        return t;
    endfunction

    function automatic logic [BLK_W-1:0] sub_shift_inv(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        t = '0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[BLK_W-1-8*(r+4*((c + r) & 3)) -: 8] = rev_sub_byte(get_byte(s, r + 4*c));
        return t;
    endfunction

    function automatic logic [BLK_W-1:0] mix_fwd(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            t[BLK_W-1-32*c -: 32] = {
                xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
        end
        return t;
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ a;
    endfunction

    function automatic logic [7:0] mulb(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
    endfunction

    function automatic logic [7:0] muld(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
    endfunction

    function automatic logic [7:0] mule(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
    endfunction

    function automatic logic [BLK_W-1:0] mix_inv(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            t[BLK_W-1-32*c -: 32] = {
                mule(a0) ^ mulb(a1) ^ muld(a2) ^ mul9(a3),
                mul9(a0) ^ mule(a1) ^ mulb(a2) ^ muld(a3),
                muld(a0) ^ mul9(a1) ^ mule(a2) ^ mulb(a3),
                mulb(a0) ^ muld(a1) ^ mul9(a2) ^ mule(a3)};
        end
        return t;
    endfunction

    // next round key from the previous one
    function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] k,
                                                  input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, sw;
        sw = {SBOX[k[23:16]] ^ rcon, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ sw;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// File: rtl/aes_cbc_ram.sv
// generic single-write, single-read ram with registered read data
module aes_cbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 11
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/aes128_cbc_block_cipher_unit.sv
// aes-128 cbc block cipher: round keys in ram, one round per cycle
//
// channel  | signals                                 | dir
// block    | block_valid/ready, block_high/low, restart | in
// result   | result_valid/ready, result_high/low       | out
// config   | cfg_we, cfg_index, cfg_data              | in
//
// a block passes the initial key addition, then ten rounds, each reading its
// round key from ram, before the next block can be accepted.
// after reset and after each key write the schedule is expanded into the ram,
// one round key a cycle, with block_ready low.
// a finished result waits in the output register; a second result waits in
// the state register until the output is free.
module aes128_cbc_block_cipher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        block_valid,
    output logic        block_ready,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        chain_restart,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_KEYLOAD,
        ST_EXPAND,
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_HOLD
    } st_t;

    localparam logic [aes_cbc_pkg::KEY_AW-1:0] LAST_KEY =
        aes_cbc_pkg::KEY_AW'(aes_cbc_pkg::ROUND_COUNT);
    localparam logic [aes_cbc_pkg::KEY_AW-1:0] KEY_ONE = aes_cbc_pkg::KEY_AW'(1);
    localparam logic [3:0] LAST_RND = 4'(aes_cbc_pkg::ROUND_COUNT);

    st_t state_reg;
    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic        dec_reg;
    logic [127:0] cv_reg, blk_reg, st_reg, exp_key_reg, res_reg;
    logic [7:0]  rcon_reg;
    logic [aes_cbc_pkg::KEY_AW-1:0] kidx_reg;
    logic [3:0]  rnd_reg;
    logic        res_valid_reg;

    logic [aes_cbc_pkg::KEY_AW-1:0] rd_addr;
    logic [127:0] rk;
    logic [127:0] round_next, fin_next, blk_in, cv_eff;
    logic accept, key_write, out_free, res_load;

    assign accept    = block_valid && block_ready;
    assign key_write = cfg_we && (cfg_index == aes_cbc_pkg::REG_KEY_HIGH ||
                                  cfg_index == aes_cbc_pkg::REG_KEY_LOW);
    assign out_free  = !res_valid_reg || result_ready;
    assign blk_in    = {block_high, block_low};
    assign cv_eff    = chain_restart ? {iv_high_reg, iv_low_reg} : cv_reg;
    // output register takes a finished block
    assign res_load  = out_free && (state_reg == ST_HOLD ||
                                    (state_reg == ST_ROUND && rnd_reg == LAST_RND));

    assign block_ready  = (state_reg == ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result_high  = res_reg[127:64];
    assign result_low   = res_reg[63:0];

    // key address for the next cycle's round
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  rd_addr = dec_reg ? LAST_KEY : '0;
            ST_LOAD:  rd_addr = dec_reg ? LAST_KEY - KEY_ONE : KEY_ONE;
            ST_ROUND:
            begin
                if (rnd_reg == LAST_RND)
                    rd_addr = '0;
                else if (dec_reg)
                    rd_addr = LAST_KEY - KEY_ONE - rnd_reg[aes_cbc_pkg::KEY_AW-1:0];
                else
                    rd_addr = rnd_reg[aes_cbc_pkg::KEY_AW-1:0] + KEY_ONE;
            end
            default:  rd_addr = '0;
        endcase
    end

    always_comb
    begin
        if (dec_reg)
        begin
            round_next = aes_cbc_pkg::sub_shift_inv(st_reg) ^ rk;
            if (rnd_reg != LAST_RND)
                round_next = aes_cbc_pkg::mix_inv(round_next);
        end
        else
        begin
            round_next = aes_cbc_pkg::sub_shift_fwd(st_reg);
            if (rnd_reg != LAST_RND)
                round_next = aes_cbc_pkg::mix_fwd(round_next);
            round_next = round_next ^ rk;
        end
        fin_next = dec_reg ? (round_next ^ cv_reg) : round_next;
    end

    aes_cbc_ram #(
        .WIDTH(aes_cbc_pkg::BLK_W),
        .DEPTH(aes_cbc_pkg::KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (state_reg == ST_EXPAND),
        .waddr (kidx_reg),
        .wdata (exp_key_reg),
        .raddr (rd_addr),
        .rdata (rk)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_KEYLOAD;
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            iv_high_reg   <= '0;
            iv_low_reg    <= '0;
            dec_reg       <= 1'b0;
            cv_reg        <= '0;
            rcon_reg      <= 8'h01;
            kidx_reg      <= '0;
            rnd_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    aes_cbc_pkg::REG_KEY_HIGH:     key_high_reg <= cfg_data;
                    aes_cbc_pkg::REG_KEY_LOW:      key_low_reg  <= cfg_data;
                    aes_cbc_pkg::REG_IV_HIGH:      iv_high_reg  <= cfg_data;
                    aes_cbc_pkg::REG_IV_LOW:       iv_low_reg   <= cfg_data;
                    aes_cbc_pkg::REG_DECRYPT_MODE: dec_reg      <= cfg_data[0];
                    default: ;
                endcase
            end

            if (res_load)
                res_valid_reg <= 1'b1;
            else if (result_ready)
                res_valid_reg <= 1'b0;

            // a key write restarts the schedule expansion
            if (key_write)
            begin
                state_reg <= ST_KEYLOAD;
            end
            else
            begin
                case (state_reg)
                    ST_KEYLOAD:
                    begin
                        exp_key_reg <= {key_high_reg, key_low_reg};
                        rcon_reg    <= 8'h01;
                        kidx_reg    <= '0;
                        state_reg   <= ST_EXPAND;
                    end
                    ST_EXPAND:
                    begin
                        exp_key_reg <= aes_cbc_pkg::key_step(exp_key_reg, rcon_reg);
                        rcon_reg    <= aes_cbc_pkg::xtime(rcon_reg);
                        kidx_reg    <= kidx_reg + KEY_ONE;
                        if (kidx_reg == LAST_KEY)
                            state_reg <= ST_IDLE;
                    end
                    ST_IDLE:
                    begin
                        if (accept)
                        begin
                            blk_reg   <= blk_in;
                            cv_reg    <= cv_eff;
                            st_reg    <= dec_reg ? blk_in : (blk_in ^ cv_eff);
                            state_reg <= ST_LOAD;
                        end
                    end
                    ST_LOAD:
                    begin
                        st_reg    <= st_reg ^ rk;
                        rnd_reg   <= 4'd1;
                        state_reg <= ST_ROUND;
                    end
                    ST_ROUND:
                    begin
                        rnd_reg <= rnd_reg + 4'd1;
                        if (rnd_reg == LAST_RND)
                        begin
                            // chaining value: ciphertext either way
                            cv_reg <= dec_reg ? blk_reg : round_next;
                            if (out_free)
                            begin
                                res_reg   <= fin_next;
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                st_reg    <= fin_next;
                                state_reg <= ST_HOLD;
                            end
                        end
                        else
                        begin
                            st_reg <= round_next;
                        end
                    end
                    ST_HOLD:
                    begin
                        if (out_free)
                        begin
                            res_reg   <= st_reg;
                            state_reg <= ST_IDLE;
                        end
                    end
                    default: state_reg <= ST_KEYLOAD;
                endcase
            end
        end
    end

    `CHK_CLK(a_key_write_blocks, key_write |=> !block_ready, "block accepted during key expansion")
    `CHK_CLK(a_one_in_flight, accept |=> !block_ready, "second block accepted while one in flight")
    `CHK_CLK(a_round_range, (state_reg == ST_ROUND) |-> (rnd_reg >= 4'd1 && rnd_reg <= LAST_RND), "round count out of range")
    `CHK_CLK(a_hold_means_full, (state_reg == ST_HOLD) |-> res_valid_reg, "holding a result while output is empty")

endmodule

// File: sim/tb_aes128_cbc_block_cipher_unit.sv
// self-checking testbench for the aes-128 cbc block cipher unit
`timescale 1ns / 100ps

module tb_aes128_cbc_block_cipher_unit;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        restart;
    } blk_beat_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        block_valid;
    logic        block_ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        chain_restart;
    logic        result_valid;
    logic        result_ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    aes128_cbc_block_cipher_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .block_valid(block_valid), .block_ready(block_ready),
        .block_high(block_high), .block_low(block_low), .chain_restart(chain_restart),
        .result_valid(result_valid), .result_ready(result_ready),
        .result_high(result_high), .result_low(result_low)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // golden cipher state
    logic [127:0] round_keys [0:10];
    logic [127:0] key_reg, iv_reg, chain_val;
    logic         mode_dec;
    logic [7:0]   inv_box [0:255];

    blk_beat_t    pending_blocks [$];
    logic [127:0] expected_blocks [$];
    int           errors;
    int           idle_cycles;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic void expand_schedule();
        logic [7:0] w [0:175];
        logic [7:0] t [0:3];
        logic [7:0] tmp, rc;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
            w[i] = key_reg[127-8*i -: 8];
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = w[i-4+j];
            if ((i % 16) == 0)
            begin
                tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
                for (int j = 0; j < 4; j++)
                    t[j] = aes_cbc_pkg::SBOX[t[j]];
                t[0] ^= rc;
                rc = gf_mul(rc, 8'h02);
            end
            for (int j = 0; j < 4; j++)
                w[i+j] = w[i-16+j] ^ t[j];
        end
        for (int r = 0; r < 11; r++)
            for (int i = 0; i < 16; i++)
                round_keys[r][127-8*i -: 8] = w[16*r+i];
    endfunction

    function automatic logic [127:0] shift_sub(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        t = '0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                if (inv)
                    t[127-8*(r+4*((c+r)&3)) -: 8] = inv_box[s[127-8*(r+4*c) -: 8]];
                else
                    t[127-8*(r+4*c) -: 8] = aes_cbc_pkg::SBOX[s[127-8*(r+4*((c+r)&3)) -: 8]];
            end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [7:0]   coef [0:3];
        logic [7:0]   a [0:3];
        logic [7:0]   v;
        logic [127:0] t;
        if (inv)
        begin
            coef[0] = 8'h0e; coef[1] = 8'h0b; coef[2] = 8'h0d; coef[3] = 8'h09;
        end
        else
        begin
            coef[0] = 8'h02; coef[1] = 8'h03; coef[2] = 8'h01; coef[3] = 8'h01;
        end
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
                a[k] = s[127-8*(4*c+k) -: 8];
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v ^= gf_mul(a[k], coef[(k-r+4)&3]);
                t[127-8*(4*c+r) -: 8] = v;
            end
        end
        return t;
    endfunction

    // one cbc step: updates the chaining value and returns the output block
    function automatic logic [127:0] cbc_block(input blk_beat_t b);
        logic [127:0] s;
        s = {b.hi, b.lo};
        if (b.restart)
            chain_val = iv_reg;
        if (!mode_dec)
        begin
            s = s ^ chain_val ^ round_keys[0];
            for (int r = 1; r <= 10; r++)
            begin
                s = shift_sub(s, 1'b0);
                if (r != 10)
                    s = mix_columns(s, 1'b0);
                s ^= round_keys[r];
            end
            chain_val = s;
        end
        else
        begin
            s ^= round_keys[10];
            for (int r = 9; r >= 0; r--)
            begin
                s = shift_sub(s, 1'b1);
                s ^= round_keys[r];
                if (r != 0)
                    s = mix_columns(s, 1'b1);
            end
            s ^= chain_val;
            chain_val = {b.hi, b.lo};
        end
        return s;
    endfunction

    // sender: bursts and gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_valid   <= 1'b0;
            block_high    <= '0;
            block_low     <= '0;
            chain_restart <= 1'b0;
            burst_left    = 4;
            gap_left      = 0;
        end
        else
        begin
            if (block_valid && block_ready)
            begin
                expected_blocks.push_back(cbc_block(pending_blocks.pop_front()));
            end
            if (block_valid && !block_ready)
            begin
                // hold the beat
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                block_valid <= 1'b0;
            end
            else if (pending_blocks.size() > 0)
            begin
                block_valid   <= 1'b1;
                block_high    <= pending_blocks[0].hi;
                block_low     <= pending_blocks[0].lo;
                chain_restart <= pending_blocks[0].restart;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            else
                block_valid <= 1'b0;
        end
    end

    // receiver: rotating stall pattern, reloaded now and then
    logic [15:0] stall_pat;
    int          pat_age;

    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] exp_blk;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_pat    = 16'hffff;
            pat_age      = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with none expected, actual %h %h",
                             $time, result_high, result_low);
                end
                else
                begin
                    exp_blk = expected_blocks.pop_front();
                    if (result_high !== exp_blk[127:64])
                    begin
                        errors++;
                        $display("%0t: result_high expected %h actual %h",
                                 $time, exp_blk[127:64], result_high);
                    end
                    if (result_low !== exp_blk[63:0])
                    begin
                        errors++;
                        $display("%0t: result_low expected %h actual %h",
                                 $time, exp_blk[63:0], result_low);
                    end
                end
            end
            pat_age++;
            if (pat_age >= 200)
            begin
                pat_age   = 0;
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
                if (stall_pat == 16'h0000)
                    stall_pat = 16'h0001;
            end
            stall_pat    = {stall_pat[0], stall_pat[15:1]};
            result_ready <= stall_pat[0];
        end
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if (!rst_n || (block_valid && block_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000)
        begin
            $display("aes128_cbc_block_cipher_unit regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            aes_cbc_pkg::REG_KEY_HIGH:
            begin
                key_reg[127:64] = data;
                expand_schedule();
            end
            aes_cbc_pkg::REG_KEY_LOW:
            begin
                key_reg[63:0] = data;
                expand_schedule();
            end
            aes_cbc_pkg::REG_IV_HIGH:      iv_reg[127:64] = data;
            aes_cbc_pkg::REG_IV_LOW:       iv_reg[63:0] = data;
            aes_cbc_pkg::REG_DECRYPT_MODE: mode_dec = data[0];
            default:                       ;
        endcase
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // lets the block drain, then allows for any trailing work
    task automatic wait_drained();
        wait (pending_blocks.size() == 0 && expected_blocks.size() == 0 && !block_valid);
        repeat (40) @(posedge clk);
    endtask

    task automatic push_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic restart);
        blk_beat_t b;
        b.hi      = hi;
        b.lo      = lo;
        b.restart = restart;
        pending_blocks.push_back(b);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 64'h0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        logic [63:0] kh, kl, ih, il;
        errors      = 0;
        idle_cycles = 0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        for (int i = 0; i < 256; i++)
            inv_box[aes_cbc_pkg::SBOX[i]] = 8'(i);
        key_reg   = '0;
        iv_reg    = '0;
        chain_val = '0;
        mode_dec  = 1'b0;
        expand_schedule();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (30) @(posedge clk);

        // reset state: zero key, zero iv, encrypt
        push_block(64'h0, 64'h0, 1'b0);
        push_block('1, '1, 1'b0);
        wait_drained();

        write_reg(aes_cbc_pkg::REG_KEY_HIGH, 64'h0001020304050607);
        write_reg(aes_cbc_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        write_reg(aes_cbc_pkg::REG_IV_HIGH, 64'h0);
        write_reg(aes_cbc_pkg::REG_IV_LOW, 64'h0);
        write_reg(aes_cbc_pkg::REG_DECRYPT_MODE, 64'h0);
        end_writes();
        push_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        push_block(64'h0, 64'h0, 1'b0);
        push_block('1, '1, 1'b0);
        push_block(64'h8000000000000000, 64'h1, 1'b0);
        wait_drained();

        // iv write alone leaves the chain in place
        write_reg(aes_cbc_pkg::REG_IV_HIGH, '1);
        write_reg(aes_cbc_pkg::REG_IV_LOW, 64'h0123456789abcdef);
        // writes to unused indexes are dropped
        write_reg(3'd5, '1);
        write_reg(3'd7, 64'h5a5a5a5a5a5a5a5a);
        end_writes();
        push_block(64'h0, 64'h0, 1'b0);
        push_block(64'h0, 64'h0, 1'b1);
        push_block('1, 64'h0, 1'b0);
        wait_drained();

        // mode change keeps the chain
        write_reg(aes_cbc_pkg::REG_DECRYPT_MODE, 64'h1);
        write_reg(3'd6, 64'h0);
        end_writes();
        push_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
        push_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
        push_block('1, '1, 1'b0);
        push_block(64'h0, 64'h0, 1'b0);
        wait_drained();

        write_reg(aes_cbc_pkg::REG_DECRYPT_MODE, 64'hfffffffffffffffe);
        end_writes();
        push_block(64'h0, '1, 1'b0);
        wait_drained();

        // random phases with the extremes in the first two
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       begin kh = '0; kl = '0; ih = '1; il = '1; end
                1:       begin kh = '1; kl = '1; ih = '0; il = '0; end
                default: begin kh = rand_word(); kl = rand_word();
                               ih = rand_word(); il = rand_word(); end
            endcase
            write_reg(aes_cbc_pkg::REG_KEY_HIGH, kh);
            write_reg(aes_cbc_pkg::REG_KEY_LOW, kl);
            write_reg(aes_cbc_pkg::REG_IV_HIGH, ih);
            write_reg(aes_cbc_pkg::REG_IV_LOW, il);
            write_reg(aes_cbc_pkg::REG_DECRYPT_MODE, 64'(ph % 2));
            end_writes();
            for (int n = 0; n < 80; n++)
                push_block(rand_word(), rand_word(), ($urandom_range(0, 7) == 0));
            wait_drained();
        end

        if (errors == 0)
            $display("aes128_cbc_block_cipher_unit regression: pass");
        else
            $display("aes128_cbc_block_cipher_unit regression: fail");
        $finish;
    end

endmodule
